[rtl/core/evpmd_pkg.sv]
// Shared types, constants and arithmetic helpers for the encoder velocity PI drive.
// Used by every module of the block; depends on nothing.
`default_nettype none

package evpmd_pkg;

  // Serial multiplier operand widths: signed multiplicand, unsigned multiplier.
  localparam int unsigned MUL_A_BITS = 40;
  localparam int unsigned MUL_B_BITS = 24;
  localparam int unsigned PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  // Datapath widths.
  localparam int unsigned SPEED_BITS = 24;
  localparam int unsigned REF_BITS   = 29;
  localparam int unsigned ERR_BITS   = 30;
  localparam int unsigned PTERM_BITS = 30;
  localparam int unsigned SUM_BITS   = 40;
  localparam int unsigned CTL_BITS   = 41;
  localparam int unsigned DUTY_BITS  = 11;

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE         = 3'd0,
    REG_MANUAL_DUTY  = 3'd1,
    REG_TARGET_SPEED = 3'd2,
    REG_GEAR_RATIO   = 3'd3,
    REG_SPEED_SCALE  = 3'd4,
    REG_PROP_GAIN    = 3'd5,
    REG_INTEG_GAIN   = 3'd6
  } reg_idx_e;

  // Register reset values.
  localparam logic        RST_MODE         = 1'b1;
  localparam logic [11:0] RST_MANUAL_DUTY  = 12'd0;
  localparam logic [20:0] RST_TARGET_SPEED = 21'd0;
  localparam logic [23:0] RST_GEAR_RATIO   = 24'd888144;
  localparam logic [23:0] RST_SPEED_SCALE  = 24'd588644;
  localparam logic [23:0] RST_PROP_GAIN    = 24'd9830;
  localparam logic [23:0] RST_INTEG_GAIN   = 24'd1147;

  // Saturation limits of the measured speed, held at product width.
  localparam logic signed [PROD_BITS-1:0] SPEED_HI =
    PROD_BITS'((64'sd1 <<< (SPEED_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_BITS-1:0] SPEED_LO = -SPEED_HI - 1;

  // Bridge direction codes.
  typedef enum logic [1:0] {
    DIR_BRAKE = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_e;

  // Control sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SPEED,
    S_REF,
    S_ERR,
    S_SUM,
    S_PROP,
    S_INTEG,
    S_CTL,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic                      mode;
    logic signed [11:0]        manual_duty;
    logic signed [20:0]        target_speed;
    logic        [23:0]        gear_ratio;
    logic        [23:0]        speed_scale;
    logic        [23:0]        prop_gain;
    logic        [23:0]        integ_gain;
  } cfg_t;

  typedef struct packed {
    logic [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] measured_speed;
    logic        [DUTY_BITS-1:0]  duty;
    logic        [1:0]            drive_dir;
    logic                         clipped;
  } out_item_t;

  // Request into and response out of the serial multiplier.
  typedef struct packed {
    logic                         start;
    logic signed [MUL_A_BITS-1:0] a;
    logic        [MUL_B_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                        busy;
    logic                        done;
    logic signed [PROD_BITS-1:0] product;
  } mul_rsp_t;

  // Round half up, then arithmetic shift right by n.
  function automatic logic signed [PROD_BITS-1:0] round_half_up(
    input logic signed [PROD_BITS-1:0] x,
    input int unsigned                 n
  );
    logic signed [PROD_BITS-1:0] bias;
    bias = PROD_BITS'(64'sd1 <<< (n - 1));
    return (x + bias) >>> n;
  endfunction

  // Clamp a wide value to the signed speed range.
  function automatic logic signed [SPEED_BITS-1:0] sat_speed(
    input logic signed [PROD_BITS-1:0] x
  );
    logic signed [SPEED_BITS-1:0] r;
    if (x > SPEED_HI) begin
      r = {1'b0, {(SPEED_BITS-1){1'b1}}};
    end else if (x < SPEED_LO) begin
      r = {1'b1, {(SPEED_BITS-1){1'b0}}};
    end else begin
      r = x[SPEED_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/evpmd_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from evpmd_pkg at instantiation.
`default_nettype none

interface evpmd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/evpmd_serial_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// Depends on evpmd_pkg for widths and the request/response structs.
`default_nettype none

module evpmd_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  evpmd_pkg::mul_req_t req_i,
  output evpmd_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned AW    = evpmd_pkg::MUL_A_BITS;
  localparam int unsigned BW    = evpmd_pkg::MUL_B_BITS;
  localparam int unsigned HW    = AW + 1;
  localparam int unsigned CNT_W = $clog2(BW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BW - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [AW-1:0] a_q;
  logic signed [HW-1:0] hi_q;
  logic [BW-1:0]        lo_q;
  logic signed [HW-1:0] addend;
  logic signed [HW-1:0] sum;

  // One multiplier bit per cycle: add the multiplicand into the high half.
  assign addend = lo_q[0] ? HW'(a_q) : '0;
  assign sum    = hi_q + addend;

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial product shifts right one place per step.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      hi_q <= '0;
      lo_q <= req_i.b;
    end else if (busy_q) begin
      hi_q <= {sum[HW-1], sum[HW-1:1]};
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = {hi_q[AW-1:0], lo_q};

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("multiplier did not start");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("multiplier done without a finished run");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= CNT_LAST))
    else $error("multiplier step count out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/evpmd_ctrl.sv]
// Control sequencer and datapath: speed estimate, PI law, saturation, result register.
// Depends on evpmd_pkg; drives the serial multiplier through mul_req_t/mul_rsp_t.
`default_nettype none

module evpmd_ctrl #(
  parameter int unsigned DUTY_MAX   = 2047,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  evpmd_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  evpmd_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output evpmd_pkg::out_item_t out_data_o,
  output evpmd_pkg::mul_req_t  mul_req_o,
  input  evpmd_pkg::mul_rsp_t  mul_rsp_i
);

  localparam int unsigned AW  = evpmd_pkg::MUL_A_BITS;
  localparam int unsigned PW  = evpmd_pkg::PROD_BITS;
  localparam int unsigned SPW = evpmd_pkg::SPEED_BITS;
  localparam int unsigned RW  = evpmd_pkg::REF_BITS;
  localparam int unsigned EW  = evpmd_pkg::ERR_BITS;
  localparam int unsigned TW  = evpmd_pkg::PTERM_BITS;
  localparam int unsigned SW  = evpmd_pkg::SUM_BITS;
  localparam int unsigned CW  = evpmd_pkg::CTL_BITS;
  localparam int unsigned DW  = evpmd_pkg::DUTY_BITS;
  localparam logic signed [CW-1:0] DMAX = CW'(DUTY_MAX);

  evpmd_pkg::ctl_state_e state_q, state_d;

  logic                  in_fire;
  logic                  out_load;
  logic                  out_valid_q;
  evpmd_pkg::out_item_t  out_q;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] last_q;
  logic [COUNT_BITS-1:0] delta;

  logic signed [SPW-1:0] speed_q;
  logic signed [RW-1:0]  ref_q;
  logic signed [EW-1:0]  err_q;
  logic signed [SW-1:0]  sum_q;
  logic signed [TW-1:0]  pterm_q;
  logic signed [SW-1:0]  iterm_q;
  logic signed [CW-1:0]  ctl_q;

  logic signed [PW-1:0]  rnd8, rnd16, rnd24;
  logic signed [SW:0]    sum_ext;
  logic signed [SW-1:0]  sum_sat;

  logic                  over, under, neg, zero, clip;
  logic signed [CW-1:0]  abs_ctl;
  logic signed [CW-1:0]  mag;
  evpmd_pkg::dir_e       dir;

  assign in_fire = in_valid_i && in_ready_o;
  assign cnt     = in_data_i.encoder_count[COUNT_BITS-1:0];
  assign delta   = cnt - last_q;

  // Rounded views of the multiplier result.
  assign rnd8  = evpmd_pkg::round_half_up(mul_rsp_i.product, 8);
  assign rnd16 = evpmd_pkg::round_half_up(mul_rsp_i.product, 16);
  assign rnd24 = evpmd_pkg::round_half_up(mul_rsp_i.product, 24);

  // Error sum with saturation at its own width.
  assign sum_ext = (SW+1)'(sum_q) + (SW+1)'(err_q);
  assign sum_sat = (sum_ext[SW] != sum_ext[SW-1]) ?
                   {sum_ext[SW], {(SW-1){~sum_ext[SW]}}} : sum_ext[SW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      evpmd_pkg::S_IDLE: begin
        if (in_fire) state_d = evpmd_pkg::S_SPEED;
      end
      evpmd_pkg::S_SPEED: begin
        if (mul_rsp_i.done) begin
          state_d = cfg_i.mode ? evpmd_pkg::S_REF : evpmd_pkg::S_OUT;
        end
      end
      evpmd_pkg::S_REF: begin
        if (mul_rsp_i.done) state_d = evpmd_pkg::S_ERR;
      end
      evpmd_pkg::S_ERR:  state_d = evpmd_pkg::S_SUM;
      evpmd_pkg::S_SUM:  state_d = evpmd_pkg::S_PROP;
      evpmd_pkg::S_PROP: begin
        if (mul_rsp_i.done) state_d = evpmd_pkg::S_INTEG;
      end
      evpmd_pkg::S_INTEG: begin
        if (mul_rsp_i.done) state_d = evpmd_pkg::S_CTL;
      end
      evpmd_pkg::S_CTL: state_d = evpmd_pkg::S_OUT;
      evpmd_pkg::S_OUT: begin
        if (out_load) state_d = evpmd_pkg::S_IDLE;
      end
      default: state_d = evpmd_pkg::S_IDLE;
    endcase
  end

  // State outputs: handshake and multiplier requests.
  always_comb begin
    in_ready_o      = 1'b0;
    out_load        = 1'b0;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = '0;
    mul_req_o.b     = '0;
    unique case (state_q)
      evpmd_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        mul_req_o.start = in_valid_i;
        mul_req_o.a     = AW'($signed(delta));
        mul_req_o.b     = cfg_i.speed_scale;
      end
      evpmd_pkg::S_SPEED: begin
        mul_req_o.start = mul_rsp_i.done && cfg_i.mode;
        mul_req_o.a     = AW'(cfg_i.target_speed);
        mul_req_o.b     = cfg_i.gear_ratio;
      end
      evpmd_pkg::S_SUM: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = AW'(err_q);
        mul_req_o.b     = cfg_i.prop_gain;
      end
      evpmd_pkg::S_PROP: begin
        mul_req_o.start = mul_rsp_i.done;
        mul_req_o.a     = sum_q;
        mul_req_o.b     = cfg_i.integ_gain;
      end
      evpmd_pkg::S_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        mul_req_o.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evpmd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Loop state: previous count sample and error sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      sum_q  <= '0;
    end else begin
      if (in_fire) last_q <= cnt;
      if (state_q == evpmd_pkg::S_SUM) sum_q <= sum_sat;
    end
  end

  // Intermediate results captured as each step finishes.
  always_ff @(posedge clk_i) begin
    if (state_q == evpmd_pkg::S_SPEED && mul_rsp_i.done) begin
      speed_q <= evpmd_pkg::sat_speed(rnd8);
      if (!cfg_i.mode) ctl_q <= CW'(cfg_i.manual_duty);
    end
    if (state_q == evpmd_pkg::S_REF && mul_rsp_i.done) ref_q <= rnd16[RW-1:0];
    if (state_q == evpmd_pkg::S_ERR) err_q <= EW'(ref_q) - EW'(speed_q);
    if (state_q == evpmd_pkg::S_PROP && mul_rsp_i.done) pterm_q <= rnd24[TW-1:0];
    if (state_q == evpmd_pkg::S_INTEG && mul_rsp_i.done) iterm_q <= rnd24[SW-1:0];
    if (state_q == evpmd_pkg::S_CTL) ctl_q <= CW'(pterm_q) + CW'(iterm_q);
  end

  // Duty limit, magnitude and direction.
  assign over    = ctl_q > DMAX;
  assign under   = ctl_q < -DMAX;
  assign clip    = over || under;
  assign neg     = ctl_q[CW-1];
  assign zero    = (ctl_q == '0);
  assign abs_ctl = neg ? -ctl_q : ctl_q;
  assign mag     = clip ? DMAX : abs_ctl;
  assign dir     = zero ? evpmd_pkg::DIR_BRAKE :
                   (neg ? evpmd_pkg::DIR_REV : evpmd_pkg::DIR_FWD);

  // Result register decouples the sink from the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.measured_speed <= speed_q;
      out_q.duty           <= mag[DW-1:0];
      out_q.drive_dir      <= dir;
      out_q.clipped        <= clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req_o.start |-> !mul_rsp_i.busy)
    else $error("multiplier started while busy");
  a_clip_not_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.clipped) |-> (out_q.drive_dir != evpmd_pkg::DIR_BRAKE))
    else $error("clipped result shows brake");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == evpmd_pkg::S_IDLE))
    else $error("result load did not complete the transaction");
`endif

endmodule

`default_nettype wire

[rtl/core/encoder_velocity_pi_motor_drive.sv]
// Top level of the encoder velocity PI motor drive: configuration registers and wiring.
// Depends on evpmd_pkg, evpmd_stream_if, evpmd_serial_mul and evpmd_ctrl.
//
// Usage: each control tick sends one transaction on in_i carrying the sampled
// encoder counter. The block answers with one transaction on out_o: measured
// speed, duty magnitude, bridge direction and the clip flag. Registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i while no tick is in flight.
// The time from input acceptance to a valid result is set by the shared
// bit-serial multiplier, which retires one multiplier bit per cycle (24 steps
// per product); velocity mode runs four products in sequence, manual mode one.
// Ticks are handled one at a time: a new tick is accepted in the cycle after
// the result is loaded. The result sits in an output register: if the
// receiver stalls, the block finishes the next tick and then waits holding
// it until the register frees. Reset clears the previous count sample, the
// error sum and all handshakes, and loads the register reset values (velocity
// mode on).
`default_nettype none

module encoder_velocity_pi_motor_drive #(
  parameter int unsigned DUTY_MAX   = 2047,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [evpmd_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [evpmd_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  evpmd_stream_if.sink                           in_i,
  evpmd_stream_if.source                         out_o
);

  evpmd_pkg::cfg_t      cfg_q;
  evpmd_pkg::mul_req_t  mul_req;
  evpmd_pkg::mul_rsp_t  mul_rsp;
  evpmd_pkg::in_item_t  in_data;
  evpmd_pkg::out_item_t out_data;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= evpmd_pkg::RST_MODE;
      cfg_q.manual_duty  <= evpmd_pkg::RST_MANUAL_DUTY;
      cfg_q.target_speed <= evpmd_pkg::RST_TARGET_SPEED;
      cfg_q.gear_ratio   <= evpmd_pkg::RST_GEAR_RATIO;
      cfg_q.speed_scale  <= evpmd_pkg::RST_SPEED_SCALE;
      cfg_q.prop_gain    <= evpmd_pkg::RST_PROP_GAIN;
      cfg_q.integ_gain   <= evpmd_pkg::RST_INTEG_GAIN;
    end else if (cfg_we_i) begin
      unique case (evpmd_pkg::reg_idx_e'(cfg_idx_i))
        evpmd_pkg::REG_MODE:         cfg_q.mode         <= cfg_data_i[0];
        evpmd_pkg::REG_MANUAL_DUTY:  cfg_q.manual_duty  <= cfg_data_i[11:0];
        evpmd_pkg::REG_TARGET_SPEED: cfg_q.target_speed <= cfg_data_i[20:0];
        evpmd_pkg::REG_GEAR_RATIO:   cfg_q.gear_ratio   <= cfg_data_i;
        evpmd_pkg::REG_SPEED_SCALE:  cfg_q.speed_scale  <= cfg_data_i;
        evpmd_pkg::REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i;
        evpmd_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  // Shared bit-serial multiplier.
  evpmd_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequencer, PI datapath and result register.
  evpmd_ctrl #(
    .DUTY_MAX   (DUTY_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

endmodule

`default_nettype wire

[bench/encoder_velocity_pi_motor_drive_test.sv]
// Testbench for the encoder velocity PI motor drive: directed and random control ticks
// checked field by field against an in-bench integer predictor of the speed and PI law.
// Depends on evpmd_pkg, evpmd_stream_if and the encoder_velocity_pi_motor_drive RTL.
`timescale 1ns / 100ps

module encoder_velocity_pi_motor_drive_test;

  localparam int unsigned DUTY_LIMIT  = 2047;
  localparam int unsigned WIDE        = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned END_WAIT    = 120;
  localparam int unsigned MAX_PRINTS  = 100;

  // The one index beyond the register list; writes to it must be ignored.
  localparam logic [evpmd_pkg::CFG_IDX_BITS-1:0] REG_IDX_SPARE = 3'd7;

  localparam logic signed [WIDE-1:0] SPEED_TOP = (80'sd1 <<< 23) - 80'sd1;
  localparam logic signed [WIDE-1:0] SPEED_BOT = -(80'sd1 <<< 23);
  localparam logic signed [WIDE-1:0] SUM_TOP   = (80'sd1 <<< 39) - 80'sd1;
  localparam logic signed [WIDE-1:0] SUM_BOT   = -(80'sd1 <<< 39);
  localparam logic signed [WIDE-1:0] CTL_TOP   = DUTY_LIMIT;

  typedef struct packed {
    logic               mode;
    logic signed [11:0] manual_duty;
    logic signed [20:0] target_speed;
    logic        [23:0] gear_ratio;
    logic        [23:0] speed_scale;
    logic        [23:0] prop_gain;
    logic        [23:0] integ_gain;
  } drive_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                                cfg_we;
  logic [evpmd_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
  logic [evpmd_pkg::CFG_DATA_BITS-1:0] cfg_data;

  evpmd_stream_if #(.payload_t(evpmd_pkg::in_item_t))  tick_if ();
  evpmd_stream_if #(.payload_t(evpmd_pkg::out_item_t)) drive_if ();

  // Predictor state and the drive results still to come.
  drive_cfg_t           settings_q;
  logic [31:0]          last_count_q;
  logic signed [39:0]   error_sum_q;
  evpmd_pkg::out_item_t predicted_drive_q[$];

  evpmd_pkg::out_item_t got_item;
  evpmd_pkg::out_item_t want_item;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned idle_pct;
  int unsigned stall_left;

  encoder_velocity_pi_motor_drive #(
    .DUTY_MAX  (DUTY_LIMIT),
    .COUNT_BITS(32)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (tick_if),
    .out_o     (drive_if)
  );

  // Free-running 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Round half up, then shift right by n with floor semantics.
  function automatic logic signed [WIDE-1:0] round_shift(input logic signed [WIDE-1:0] x,
                                                         input int unsigned n);
    return (x + (80'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Advance the predicted state by one control tick and return the expected drive.
  function automatic evpmd_pkg::out_item_t predict_drive(input logic [31:0] cnt);
    logic signed [31:0]     delta;
    logic signed [WIDE-1:0] prod;
    logic signed [WIDE-1:0] speed;
    logic signed [WIDE-1:0] err;
    logic signed [WIDE-1:0] sum_next;
    logic signed [WIDE-1:0] ctl;
    logic                   clip;
    evpmd_pkg::out_item_t   res;
    delta = cnt - last_count_q;
    last_count_q = cnt;
    prod = delta * $signed({1'b0, settings_q.speed_scale});
    speed = round_shift(prod, 8);
    if (speed > SPEED_TOP) begin
      speed = SPEED_TOP;
    end else if (speed < SPEED_BOT) begin
      speed = SPEED_BOT;
    end
    if (settings_q.mode) begin
      prod = $signed(settings_q.target_speed) * $signed({1'b0, settings_q.gear_ratio});
      err = round_shift(prod, 16) - speed;
      sum_next = error_sum_q + err;
      if (sum_next > SUM_TOP) begin
        sum_next = SUM_TOP;
      end else if (sum_next < SUM_BOT) begin
        sum_next = SUM_BOT;
      end
      error_sum_q = sum_next[39:0];
      prod = $signed({1'b0, settings_q.prop_gain}) * err;
      ctl = round_shift(prod, 24);
      prod = $signed({1'b0, settings_q.integ_gain}) * sum_next;
      ctl = ctl + round_shift(prod, 24);
    end else begin
      ctl = $signed(settings_q.manual_duty);
    end
    // Only a value strictly beyond the limit raises the clip flag.
    clip = 1'b0;
    if (ctl > CTL_TOP) begin
      ctl = CTL_TOP;
      clip = 1'b1;
    end else if (ctl < -CTL_TOP) begin
      ctl = -CTL_TOP;
      clip = 1'b1;
    end
    res.measured_speed = speed[evpmd_pkg::SPEED_BITS-1:0];
    res.clipped = clip;
    if (ctl > 0) begin
      res.drive_dir = evpmd_pkg::DIR_FWD;
      res.duty = ctl[evpmd_pkg::DUTY_BITS-1:0];
    end else if (ctl < 0) begin
      res.drive_dir = evpmd_pkg::DIR_REV;
      res.duty = evpmd_pkg::DUTY_BITS'(-ctl);
    end else begin
      res.drive_dir = evpmd_pkg::DIR_BRAKE;
      res.duty = '0;
    end
    return res;
  endfunction

  function automatic drive_cfg_t reset_settings();
    drive_cfg_t c;
    c.mode = evpmd_pkg::RST_MODE;
    c.manual_duty = evpmd_pkg::RST_MANUAL_DUTY;
    c.target_speed = evpmd_pkg::RST_TARGET_SPEED;
    c.gear_ratio = evpmd_pkg::RST_GEAR_RATIO;
    c.speed_scale = evpmd_pkg::RST_SPEED_SCALE;
    c.prop_gain = evpmd_pkg::RST_PROP_GAIN;
    c.integ_gain = evpmd_pkg::RST_INTEG_GAIN;
    return c;
  endfunction

  // Pick a register value of width w, weighted toward zero, extremes and small sizes.
  function automatic logic [23:0] pick_value(input int unsigned w, input logic is_signed);
    logic [23:0] full;
    int unsigned roll;
    full = {24{1'b1}} >> (24 - w);
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return full;
    if (roll < 30) return is_signed ? (full >> 1) : full;
    if (roll < 40) return is_signed ? (full ^ (full >> 1)) : '0;
    if (roll < 70) begin
      if (is_signed && $urandom_range(1) == 1) begin
        return (24'd0 - 24'($urandom_range(1023))) & full;
      end
      return 24'($urandom_range(1023));
    end
    return 24'($urandom) & full;
  endfunction

  function automatic drive_cfg_t random_settings(input logic vel);
    drive_cfg_t c;
    c.mode = vel;
    c.manual_duty = 12'(pick_value(12, 1'b1));
    c.target_speed = 21'(pick_value(21, 1'b1));
    c.gear_ratio = pick_value(24, 1'b0);
    c.speed_scale = pick_value(24, 1'b0);
    c.prop_gain = pick_value(24, 1'b0);
    c.integ_gain = pick_value(24, 1'b0);
    return c;
  endfunction

  // Mostly plausible encoder motion, sometimes a jump to an arbitrary count.
  function automatic logic [31:0] next_count(input logic [31:0] cur);
    int unsigned roll;
    logic [31:0] step;
    roll = $urandom_range(99);
    if (roll < 20) return $urandom;
    if (roll < 60) begin
      step = $urandom_range(300);
    end else if (roll < 90) begin
      step = $urandom_range(65535);
    end else begin
      step = $urandom;
    end
    return ($urandom_range(1) == 1) ? cur + step : cur - step;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Present one encoder sample and hold it until the transaction completes.
  task automatic send_tick(input logic [31:0] cnt);
    if ($urandom_range(99) < idle_pct) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(130, 1)) @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data <= evpmd_pkg::in_item_t'(cnt);
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    predicted_drive_q.push_back(predict_drive(cnt));
  endtask

  // Wait until every predicted drive result has been received.
  task automatic drain_results();
    tick_if.valid <= 1'b0;
    while (predicted_drive_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one register; bits above its width carry random junk.
  task automatic write_reg(input logic [evpmd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [23:0] val, input int unsigned w);
    logic [23:0] keep;
    keep = {24{1'b1}} >> (24 - w);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= (24'($urandom) & ~keep) | (val & keep);
    @(posedge clk_i);
  endtask

  // Program all registers while the block is idle, plus one write to an unused index.
  task automatic load_settings(input drive_cfg_t c);
    drain_results();
    write_reg(evpmd_pkg::REG_MODE, 24'(c.mode), 1);
    write_reg(evpmd_pkg::REG_MANUAL_DUTY, 24'(c.manual_duty), 12);
    write_reg(evpmd_pkg::REG_TARGET_SPEED, 24'(c.target_speed), 21);
    write_reg(evpmd_pkg::REG_GEAR_RATIO, c.gear_ratio, 24);
    write_reg(evpmd_pkg::REG_SPEED_SCALE, c.speed_scale, 24);
    write_reg(evpmd_pkg::REG_PROP_GAIN, c.prop_gain, 24);
    write_reg(evpmd_pkg::REG_INTEG_GAIN, c.integ_gain, 24);
    write_reg(REG_IDX_SPARE, 24'($urandom), 24);
    cfg_we <= 1'b0;
    settings_q = c;
    @(posedge clk_i);
  endtask

  // Reset register values: standstill gives brake, then small moves both ways.
  task automatic test_reset_defaults();
    send_tick(32'h0000_0000);
    send_tick(32'd100);
    send_tick(32'd37);
    send_tick(32'hFFFF_FFF0);
  endtask

  // Counter wrap with the extreme deltas; unit scale puts the speed right at its limits.
  task automatic test_count_wrap();
    drive_cfg_t  c;
    logic [31:0] wrap_counts [5];
    wrap_counts = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000};
    c = reset_settings();
    c.speed_scale = 24'd1;
    load_settings(c);
    foreach (wrap_counts[i]) send_tick(wrap_counts[i]);
  endtask

  // Manual passthrough at the duty limits, beyond them, and at zero.
  task automatic test_manual_duty();
    drive_cfg_t         c;
    logic signed [11:0] duty_cases [6];
    duty_cases = '{12'sd2047, -12'sd2047, -12'sd2048, 12'sd0, 12'sd1, -12'sd1};
    c = reset_settings();
    c.mode = 1'b0;
    foreach (duty_cases[i]) begin
      c.manual_duty = duty_cases[i];
      load_settings(c);
      send_tick(next_count(last_count_q));
    end
  endtask

  // Proportional path alone lands the control value at and beyond the limit, and near zero.
  task automatic test_clip_edges();
    drive_cfg_t         c;
    logic signed [20:0] targets [6];
    targets = '{21'sd4094, 21'sd4096, -21'sd4094, -21'sd4096, -21'sd1, 21'sd1};
    c = reset_settings();
    c.speed_scale = '0;
    c.gear_ratio = 24'd65536;
    c.prop_gain = 24'h80_0000;
    c.integ_gain = '0;
    foreach (targets[i]) begin
      c.target_speed = targets[i];
      load_settings(c);
      send_tick(next_count(last_count_q));
    end
  endtask

  // Random settings per phase, with all-max and all-min phases and one idle-free phase.
  task automatic test_random_settings();
    drive_cfg_t  c;
    logic [31:0] cnt;
    logic        vel;
    for (int phase = 0; phase < 10; phase++) begin
      vel = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(1));
      c = random_settings(vel);
      if (phase == 4) begin
        c.manual_duty = 12'sd2047;
        c.target_speed = 21'sd1048575;
        c.gear_ratio = '1;
        c.speed_scale = '1;
        c.prop_gain = '1;
        c.integ_gain = '1;
      end else if (phase == 5) begin
        c.manual_duty = -12'sd2048;
        c.target_speed = -21'sd1048576;
        c.gear_ratio = '0;
        c.speed_scale = '0;
        c.prop_gain = '0;
        c.integ_gain = '0;
      end
      idle_pct = (phase == 2) ? 0 : 14;
      load_settings(c);
      cnt = last_count_q;
      repeat (65) begin
        cnt = next_count(cnt);
        send_tick(cnt);
      end
    end
    idle_pct = 14;
  endtask

  // Push the error sum hard positive, then hard negative, so the integral term dominates.
  task automatic test_large_error_sum();
    drive_cfg_t  c;
    logic [31:0] cnt;
    c = reset_settings();
    c.target_speed = 21'sd1048575;
    c.gear_ratio = '1;
    c.speed_scale = '1;
    c.prop_gain = pick_value(24, 1'b0);
    c.integ_gain = '1;
    load_settings(c);
    cnt = last_count_q;
    // A speed pinned at its negative limit keeps the error large and positive.
    repeat (40) begin
      cnt = cnt - $urandom_range(32'h7FFF_FFFF, 256);
      send_tick(cnt);
    end
    c.target_speed = -21'sd1048576;
    c.prop_gain = pick_value(24, 1'b0);
    c.integ_gain = pick_value(24, 1'b0);
    idle_pct = 0;
    load_settings(c);
    cnt = last_count_q;
    repeat (40) begin
      cnt = cnt + $urandom_range(32'h7FFF_FFFF, 256);
      send_tick(cnt);
    end
    idle_pct = 14;
  endtask

  // Receiver: short random stalls and, rarely, a long one so a finished result waits.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      drive_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(9999) < 1) begin
      drive_if.ready <= 1'b0;
      stall_left <= $urandom_range(200, 100);
    end else begin
      drive_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && drive_if.valid && drive_if.ready) begin
      got_item = drive_if.data;
      if (predicted_drive_q.size() == 0) begin
        report_mismatch("result with nothing expected", got_item.measured_speed, 0);
      end else begin
        want_item = predicted_drive_q.pop_front();
        if (got_item.measured_speed !== want_item.measured_speed) begin
          report_mismatch("measured_speed", got_item.measured_speed, want_item.measured_speed);
        end
        if (got_item.duty !== want_item.duty) begin
          report_mismatch("duty", got_item.duty, want_item.duty);
        end
        if (got_item.drive_dir !== want_item.drive_dir) begin
          report_mismatch("drive_dir", got_item.drive_dir, want_item.drive_dir);
        end
        if (got_item.clipped !== want_item.clipped) begin
          report_mismatch("clipped", got_item.clipped, want_item.clipped);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (drive_if.valid && drive_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, run the tests in turn, then let any stray result show up.
  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    tick_if.valid = 1'b0;
    tick_if.data = '0;
    drive_if.ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    stall_left = 0;
    idle_pct = 14;
    settings_q = reset_settings();
    last_count_q = '0;
    error_sum_q = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_count_wrap();
    test_manual_duty();
    test_clip_edges();
    test_random_settings();
    test_large_error_sum();

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && predicted_drive_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/evpmd_pkg.sv
rtl/core/evpmd_stream_if.sv
rtl/core/evpmd_serial_mul.sv
rtl/core/evpmd_ctrl.sv
rtl/core/encoder_velocity_pi_motor_drive.sv
bench/encoder_velocity_pi_motor_drive_test.sv
